>>> hw/rtl/isq_pkg.sv
// Shared types, widths and codes of the indexed sequence store.
package isq_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_TAIL  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT_AT  = 3'd4,
        CMD_ERASE_AT   = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SHIFT,
        S_WRVAL,
        S_FILL
    } t_state;

endpackage

>>> hw/rtl/isq_if.sv
// Request and response channel interfaces of the indexed sequence store.
interface isq_req_if;
    logic                              valid;
    logic                              ready;
    logic [isq_pkg::CMD_W-1:0]         command;
    logic [isq_pkg::POS_W-1:0]         position;
    logic signed [isq_pkg::DATA_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface isq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [isq_pkg::DATA_W-1:0]   popped_value;
    logic [isq_pkg::COUNT_W-1:0]         element_count;
    logic [isq_pkg::STATUS_W-1:0]        status;

    modport source (output valid, popped_value, element_count, status, input ready);
    modport sink   (input valid, popped_value, element_count, status, output ready);
endinterface

>>> hw/rtl/isq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/indexed_sequence_store_top.sv
// Top level of the indexed sequence store: a bounded circular deque in one RAM.
//
// Holds up to CAPACITY signed values in a circular RAM addressed from a head
// pointer, one request at a time, one response per request. Push, clear and
// every rejected request are answered from the idle state; pops go through one
// RAM read. Insert at a position inside the store shifts the entries from the
// position to the end up one place, then writes the value; erase shifts the
// entries behind the position down one place; one moved entry per cycle through
// the RAM's single read and write ports. Insert at or past the end pads with
// zeros, one RAM write per cycle. A new request is taken once the previous one
// has finished and the response register is free or draining. No clearing pass runs after reset.
module indexed_sequence_store_top #(
    parameter int CAPACITY    = isq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = isq_pkg::VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isq_req_if.sink   i_req,
    isq_rsp_if.source o_rsp
);

    localparam int HW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = ((CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W) + 1;
    localparam int DW   = isq_pkg::DATA_W;
    localparam int VW   = VALUE_WIDTH;

    isq_pkg::t_state r_state, n_state;

    logic [HW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wdst, n_wdst;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_wv, n_wv;
    logic          r_erase, n_erase;
    logic [VW-1:0] r_val, n_val;

    logic                           r_o_valid, n_o_valid;
    logic [DW-1:0]                  r_o_popped, n_o_popped;
    logic [isq_pkg::COUNT_W-1:0]    r_o_count, n_o_count;
    isq_pkg::t_status               r_o_status, n_o_status;

    logic          mem_we;
    logic [HW-1:0] mem_waddr;
    logic [VW-1:0] mem_wdata;
    logic [HW-1:0] mem_raddr;
    logic [VW-1:0] mem_rdata;

    logic             req_fire;
    isq_pkg::t_cmd    req_cmd;
    logic [PW-1:0]    pos_e;
    logic [PW-1:0]    cnt_e;
    logic [VW-1:0]    in_val;
    logic             is_full;
    logic             is_empty;
    logic             ins_inside;
    logic             ins_overflow;
    logic             erase_range;
    logic             shift_done;
    logic             fill_done;

    function automatic logic [HW-1:0] f_slot(input logic [HW-1:0] h, input logic [CW-1:0] i);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(i);
        if (s >= (CW+1)'(CAPACITY)) begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[HW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_to_out(input logic [VW-1:0] d);
        logic [DW+VW-1:0] x;
        x = {{DW{d[VW-1]}}, d};
        return x[DW-1:0];
    endfunction

    isq_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == isq_pkg::S_IDLE) && (!r_o_valid || o_rsp.ready);
    assign req_fire    = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.popped_value  = r_o_popped;
    assign o_rsp.element_count = r_o_count;
    assign o_rsp.status        = r_o_status;

    always_comb begin
        logic [DW+VW-1:0] ext;
        ext    = {{VW{i_req.value[DW-1]}}, i_req.value};
        in_val = ext[VW-1:0];
    end

    always_comb begin
        if ((isq_pkg::t_cmd'(i_req.command) == isq_pkg::CMD_INSERT_AT)
                && (i_req.position == '0)) begin
            req_cmd = isq_pkg::CMD_PUSH_FRONT;
        end else begin
            req_cmd = isq_pkg::t_cmd'(i_req.command);
        end
    end

    assign pos_e        = PW'(i_req.position);
    assign cnt_e        = PW'(r_count);
    assign is_full      = (r_count >= CW'(CAPACITY));
    assign is_empty     = (r_count == '0);
    assign ins_inside   = (pos_e < cnt_e);
    assign ins_overflow = ((pos_e + PW'(2)) > PW'(CAPACITY));
    assign erase_range  = (pos_e >= cnt_e);
    assign shift_done   = (r_left == '0);
    assign fill_done    = (r_idx == (r_pos + CW'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isq_pkg::S_IDLE: begin
                if (req_fire) begin
                    unique case (req_cmd)
                        isq_pkg::CMD_POP_BACK,
                        isq_pkg::CMD_POP_FRONT: begin
                            if (!is_empty) n_state = isq_pkg::S_POP;
                        end
                        isq_pkg::CMD_INSERT_AT: begin
                            if (ins_inside) begin
                                if (!is_full) n_state = isq_pkg::S_SHIFT;
                            end else if (!ins_overflow) begin
                                n_state = isq_pkg::S_FILL;
                            end
                        end
                        isq_pkg::CMD_ERASE_AT: begin
                            if (!erase_range) n_state = isq_pkg::S_SHIFT;
                        end
                        default: n_state = isq_pkg::S_IDLE;
                    endcase
                end
            end
            isq_pkg::S_POP:   n_state = isq_pkg::S_IDLE;
            isq_pkg::S_SHIFT: begin
                if (shift_done) begin
                    n_state = r_erase ? isq_pkg::S_IDLE : isq_pkg::S_WRVAL;
                end
            end
            isq_pkg::S_WRVAL: n_state = isq_pkg::S_IDLE;
            isq_pkg::S_FILL: begin
                if (fill_done) n_state = isq_pkg::S_IDLE;
            end
            default: n_state = isq_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM control and response
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_wdst     = r_wdst;
        n_left     = r_left;
        n_pos      = r_pos;
        n_wv       = r_wv;
        n_erase    = r_erase;
        n_val      = r_val;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_popped = r_o_popped;
        n_o_count  = r_o_count;
        n_o_status = r_o_status;
        mem_we     = 1'b0;
        mem_waddr  = f_slot(r_head, r_wdst);
        mem_wdata  = mem_rdata;
        mem_raddr  = f_slot(r_head, r_idx);

        unique case (r_state)
            isq_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_o_valid  = 1'b1;
                    n_o_popped = '0;
                    n_o_count  = isq_pkg::COUNT_W'(r_count);
                    n_o_status = isq_pkg::ST_OK;
                    n_val      = in_val;
                    n_pos      = CW'(i_req.position);
                    n_wv       = 1'b0;
                    unique case (req_cmd)
                        isq_pkg::CMD_PUSH_TAIL: begin
                            if (is_full) begin
                                n_o_status = isq_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = f_slot(r_head, r_count);
                                mem_wdata = in_val;
                                n_count   = r_count + CW'(1);
                                n_o_count = isq_pkg::COUNT_W'(r_count + CW'(1));
                            end
                        end
                        isq_pkg::CMD_POP_BACK: begin
                            if (is_empty) begin
                                n_o_status = isq_pkg::ST_EMPTY;
                            end else begin
                                n_o_valid = 1'b0;
                                mem_raddr = f_slot(r_head, r_count - CW'(1));
                                n_count   = r_count - CW'(1);
                            end
                        end
                        isq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                n_o_status = isq_pkg::ST_FULL;
                            end else begin
                                n_head    = (r_head == '0) ? HW'(CAPACITY - 1)
                                                           : r_head - HW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = n_head;
                                mem_wdata = in_val;
                                n_count   = r_count + CW'(1);
                                n_o_count = isq_pkg::COUNT_W'(r_count + CW'(1));
                            end
                        end
                        isq_pkg::CMD_POP_FRONT: begin
                            if (is_empty) begin
                                n_o_status = isq_pkg::ST_EMPTY;
                            end else begin
                                n_o_valid = 1'b0;
                                mem_raddr = r_head;
                                n_head    = f_slot(r_head, CW'(1));
                                n_count   = r_count - CW'(1);
                            end
                        end
                        isq_pkg::CMD_INSERT_AT: begin
                            if (ins_inside) begin
                                if (is_full) begin
                                    n_o_status = isq_pkg::ST_FULL;
                                end else begin
                                    n_o_valid = 1'b0;
                                    n_erase   = 1'b0;
                                    n_idx     = r_count - CW'(1);
                                    n_left    = r_count - CW'(i_req.position);
                                end
                            end else if (ins_overflow) begin
                                n_o_status = isq_pkg::ST_FULL;
                            end else begin
                                n_o_valid = 1'b0;
                                n_idx     = r_count;
                            end
                        end
                        isq_pkg::CMD_ERASE_AT: begin
                            if (erase_range) begin
                                n_o_status = isq_pkg::ST_RANGE;
                            end else begin
                                n_o_valid = 1'b0;
                                n_erase   = 1'b1;
                                n_idx     = CW'(i_req.position) + CW'(1);
                                n_left    = r_count - CW'(1) - CW'(i_req.position);
                            end
                        end
                        isq_pkg::CMD_CLEAR: begin
                            n_count   = '0;
                            n_head    = '0;
                            n_o_count = '0;
                        end
                        default: n_o_status = isq_pkg::ST_OK;
                    endcase
                end
            end
            isq_pkg::S_POP: begin
                n_o_valid  = 1'b1;
                n_o_popped = f_to_out(mem_rdata);
                n_o_count  = isq_pkg::COUNT_W'(r_count);
                n_o_status = isq_pkg::ST_OK;
            end
            isq_pkg::S_SHIFT: begin
                // read one entry, write it back one place over on the next cycle
                if (r_left != '0) begin
                    n_wdst = r_erase ? r_idx - CW'(1) : r_idx + CW'(1);
                    n_idx  = r_erase ? r_idx + CW'(1) : r_idx - CW'(1);
                    n_left = r_left - CW'(1);
                    n_wv   = 1'b1;
                end else begin
                    n_wv   = 1'b0;
                end
                mem_we = r_wv;
                if (shift_done && r_erase) begin
                    n_count    = r_count - CW'(1);
                    n_o_valid  = 1'b1;
                    n_o_popped = '0;
                    n_o_count  = isq_pkg::COUNT_W'(r_count - CW'(1));
                    n_o_status = isq_pkg::ST_OK;
                end
            end
            isq_pkg::S_WRVAL: begin
                mem_we     = 1'b1;
                mem_waddr  = f_slot(r_head, r_pos);
                mem_wdata  = r_val;
                n_count    = r_count + CW'(1);
                n_o_valid  = 1'b1;
                n_o_popped = '0;
                n_o_count  = isq_pkg::COUNT_W'(r_count + CW'(1));
                n_o_status = isq_pkg::ST_OK;
            end
            isq_pkg::S_FILL: begin
                // pad with zeros, value at the requested position
                mem_we    = 1'b1;
                mem_waddr = f_slot(r_head, r_idx);
                mem_wdata = (r_idx == r_pos) ? r_val : '0;
                n_idx     = r_idx + CW'(1);
                if (fill_done) begin
                    n_count    = r_idx + CW'(1);
                    n_o_valid  = 1'b1;
                    n_o_popped = '0;
                    n_o_count  = isq_pkg::COUNT_W'(r_idx + CW'(1));
                    n_o_status = isq_pkg::ST_OK;
                end
            end
            default: n_o_valid = r_o_valid && !o_rsp.ready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isq_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_wv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_wv      <= n_wv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_wdst     <= n_wdst;
        r_left     <= n_left;
        r_pos      <= n_pos;
        r_erase    <= n_erase;
        r_val      <= n_val;
        r_o_popped <= n_o_popped;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
    end

endmodule
